// ===== design/twil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twil_pkg
// Shared types and constants for the trie word insert and lookup block.
// ----------------------------------------------------------------------------
package twil_pkg;

    localparam int NODE_COUNT_DEF    = 1024;
    localparam int ALPHABET_SIZE_DEF = 26;

    localparam int LETTER_W  = 5;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic latch;
        logic walk;
        logic mark_take;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic item_last;
        logic need_mark;
        logic out_free;
    } t_status;

endpackage

// ===== design/twil_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twil_dp
// Datapath: child link table, word end marks, node allocator, walk state
// and the output holding register.
// ----------------------------------------------------------------------------
module twil_dp #(
    parameter int NODE_COUNT    = twil_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = twil_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twil_pkg::t_cmd                i_cmd,
    input  logic                          i_kind,
    input  logic [twil_pkg::LETTER_W-1:0] i_letter,
    input  logic                          i_last,
    input  logic                          i_out_ready,
    output twil_pkg::t_status             o_status,
    output logic                          o_out_valid,
    output logic                          o_found,
    output logic                          o_pool_full,
    output logic                          o_op_echo
);

    localparam int NW         = $clog2(NODE_COUNT);
    localparam int LW         = $clog2(ALPHABET_SIZE);
    localparam int AW         = NW + LW;
    localparam int LINK_DEPTH = 1 << AW;

    logic [NW-1:0] r_links [0:LINK_DEPTH-1];
    logic          r_marks [0:NODE_COUNT-1];

    logic [NW-1:0] r_link_q;
    logic          r_mark_q;
    logic [AW-1:0] r_slot;
    logic          r_kind;
    logic          r_last;
    logic          r_bad;
    logic          r_skip;
    logic [NW-1:0] r_cur;
    logic [NW:0]   r_free;
    logic          r_lost;
    logic          r_ovf;
    logic          r_found;
    logic          r_full;
    logic          r_echo;
    logic          r_out_valid;
    logic          r_out_found;
    logic          r_out_full;
    logic          r_out_echo;
    logic [AW-1:0] r_clr_cnt;

    logic          w_letter_bad;
    logic [AW-1:0] w_rd_slot;
    logic          w_link_zero;
    logic          w_pool_empty;
    logic          w_alloc;
    logic          w_step_old;
    logic [NW-1:0] w_child;
    logic          n_lost;
    logic          n_ovf;
    logic          w_mark_we;

    assign w_letter_bad = (32'(i_letter) >= ALPHABET_SIZE);
    assign w_rd_slot    = {r_cur, LW'(i_letter)};

    always_comb begin
        w_link_zero  = (r_link_q == '0);
        w_pool_empty = (r_free == (NW + 1)'(NODE_COUNT));
        w_alloc      = !r_skip && w_link_zero && (r_kind == twil_pkg::KIND_INSERT)
                       && !w_pool_empty;
        w_step_old   = !r_skip && !w_link_zero;
        w_child      = w_alloc ? r_free[NW-1:0] : r_link_q;
        n_lost       = r_lost || r_bad
                       || (!r_skip && w_link_zero && (r_kind == twil_pkg::KIND_FIND));
        n_ovf        = r_ovf
                       || (!r_skip && w_link_zero && (r_kind == twil_pkg::KIND_INSERT)
                           && w_pool_empty);
        // A new node gets its mark written here, so marks need no clearing pass.
        w_mark_we    = i_cmd.walk && (w_alloc || (w_step_old && r_last
                       && (r_kind == twil_pkg::KIND_INSERT)));
    end

    always_comb begin
        o_status.clear_done = &r_clr_cnt;
        o_status.item_last  = r_last;
        o_status.need_mark  = r_last && (r_kind == twil_pkg::KIND_FIND) && w_step_old;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Link table: cleared entry by entry after reset, then written once for each allocated node.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_links[r_clr_cnt] <= '0;
        end else if (i_cmd.walk && w_alloc) begin
            r_links[r_slot] <= r_free[NW-1:0];
        end
        if (i_cmd.latch) begin
            r_link_q <= r_links[w_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            r_marks[w_child] <= r_last;
        end
        r_mark_q <= r_marks[w_child];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_slot <= w_rd_slot;
            r_kind <= i_kind;
            r_last <= i_last;
            r_bad  <= w_letter_bad;
            r_skip <= r_lost || r_ovf || w_letter_bad;
        end
        if (i_cmd.walk && r_last) begin
            r_found <= (r_kind == twil_pkg::KIND_INSERT) && !n_lost && !n_ovf;
            r_full  <= n_ovf;
            r_echo  <= r_kind;
        end else if (i_cmd.mark_take) begin
            r_found <= r_mark_q;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_found;
            r_out_full  <= r_full;
            r_out_echo  <= r_echo;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_free      <= (NW + 1)'(1);
            r_lost      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_cnt   <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.walk) begin
                if (w_alloc) begin
                    r_free <= r_free + (NW + 1)'(1);
                end
                if (r_last) begin
                    r_cur  <= '0;
                    r_lost <= 1'b0;
                    r_ovf  <= 1'b0;
                end else begin
                    if (w_alloc || w_step_old) begin
                        r_cur <= w_child;
                    end
                    r_lost <= n_lost;
                    r_ovf  <= n_ovf;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_pool_full = r_out_full;
    assign o_op_echo   = r_out_echo;

endmodule

// ===== design/twil_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twil_ctrl
// Controller: sequences the clearing pass and the steps of each letter.
// ----------------------------------------------------------------------------
module twil_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  twil_pkg::t_status i_status,
    output twil_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_MARK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_status.item_last) begin
                    n_state = S_IDLE;
                end else if (i_status.need_mark) begin
                    n_state = S_MARK;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_MARK: begin
                o_cmd.mark_take = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

endmodule

// ===== design/trie_word_insert_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_word_insert_lookup
// Prefix tree over a fixed node pool: inserts and finds words letter by letter.
// ----------------------------------------------------------------------------
// Words enter on the slave stream one letter per transaction: tdata carries the
// letter index, tuser the kind (insert or find) and tlast marks the final
// letter. One result transaction leaves on the master stream for each word,
// with found and pool_full in tdata and the word's kind echoed in tuser.
// For every letter the child link is read from the link table in the accept
// cycle and the walk or node allocation follows in the next. After the last
// letter of an insert, or of a find whose path breaks off, the block goes to
// the emit step; the last letter of a find whose path exists passes through
// a mark step first, because the word end mark is read from its own memory.
// The emit step loads the result into the output register.
// After reset the link table of 2**(clog2(NODE_COUNT) + clog2(ALPHABET_SIZE))
// entries (32768 by default) is cleared one entry per cycle, and
// s_axis_tready stays low until it is done. When the receiver stalls, the
// result waits in the output register and the block keeps taking letters of
// the next word; it stops only when a second result would need that register.
// ----------------------------------------------------------------------------
module trie_word_insert_lookup #(
    parameter int NODE_COUNT    = twil_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET_SIZE = twil_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [twil_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [4:0] letter
    input  logic [0:0]                     s_axis_tuser,   // [0] kind
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [twil_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [0] found, [1] pool_full
    output logic [0:0]                     m_axis_tuser    // [0] op_echo
);

    twil_pkg::t_cmd    w_cmd;
    twil_pkg::t_status w_status;
    logic              w_found;
    logic              w_pool_full;
    logic              w_op_echo;

    twil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    twil_dp #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_kind      (s_axis_tuser[0]),
        .i_letter    (s_axis_tdata[twil_pkg::LETTER_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_found     (w_found),
        .o_pool_full (w_pool_full),
        .o_op_echo   (w_op_echo)
    );

    assign m_axis_tdata = {{(twil_pkg::M_TDATA_W - 2){1'b0}}, w_pool_full, w_found};
    assign m_axis_tuser = w_op_echo;

endmodule
